/* hw/rtl/gdas_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gdas_pkg: shared types, microcode program and calendar tables
// Control word layout, datapath flags and month-length functions for the
// Gregorian date add/subtract block.
// ----------------------------------------------------------------------------
package gdas_pkg;

	localparam int unsigned IN_TDATA_W  = 48;
	localparam int unsigned OUT_TDATA_W = 32;
	localparam int unsigned UPC_W       = 4;

	localparam int unsigned YEAR_DAYS  = 365;
	localparam int unsigned LEAP_CYCLE = 400;
	localparam int unsigned MONTHS     = 12;

	// year / 400 as (year * QUO_MUL) >> QUO_SHIFT, at most one low
	localparam int unsigned QUO_MUL   = 41943;
	localparam int unsigned QUO_SHIFT = 24;

	typedef logic [UPC_W-1:0] upc_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_QUO,
		OP_REM,
		OP_CLAMP,
		OP_DOY,
		OP_PREP,
		OP_YSTEP,
		OP_YEND,
		OP_MSTEP,
		OP_DONE,
		OP_FAIL,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_ADVANCE,
		C_FITS,
		C_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		upc_t  target;
	} uword_t;

	typedef struct packed {
		logic no_input;
		logic advance;
		logic fits;
		logic more;
		logic out_busy;
	} flags_t;

	localparam upc_t UA_IDLE  = upc_t'(0);
	localparam upc_t UA_QUO   = upc_t'(1);
	localparam upc_t UA_REM   = upc_t'(2);
	localparam upc_t UA_CLAMP = upc_t'(3);
	localparam upc_t UA_DOY   = upc_t'(4);
	localparam upc_t UA_PREP  = upc_t'(5);
	localparam upc_t UA_YEAR  = upc_t'(6);
	localparam upc_t UA_YCHK  = upc_t'(7);
	localparam upc_t UA_FAIL  = upc_t'(8);
	localparam upc_t UA_YEND  = upc_t'(9);
	localparam upc_t UA_MONTH = upc_t'(10);
	localparam upc_t UA_DONE  = upc_t'(11);
	localparam upc_t UA_EMIT  = upc_t'(12);
	localparam upc_t UA_BACK  = upc_t'(13);

	// microcode: a taken condition jumps to target, otherwise fall through
	function automatic uword_t urom(upc_t a);
		uword_t w;
		case (a)
			UA_IDLE:  w = '{OP_LOAD,  C_NO_INPUT, UA_IDLE};
			UA_QUO:   w = '{OP_QUO,   C_NEVER,    UA_IDLE};
			UA_REM:   w = '{OP_REM,   C_NEVER,    UA_IDLE};
			UA_CLAMP: w = '{OP_CLAMP, C_NEVER,    UA_IDLE};
			UA_DOY:   w = '{OP_DOY,   C_NEVER,    UA_IDLE};
			UA_PREP:  w = '{OP_PREP,  C_NEVER,    UA_IDLE};
			UA_YEAR:  w = '{OP_YSTEP, C_ADVANCE,  UA_YEAR};
			UA_YCHK:  w = '{OP_NONE,  C_FITS,     UA_YEND};
			UA_FAIL:  w = '{OP_FAIL,  C_ALWAYS,   UA_EMIT};
			UA_YEND:  w = '{OP_YEND,  C_NEVER,    UA_IDLE};
			UA_MONTH: w = '{OP_MSTEP, C_MORE,     UA_MONTH};
			UA_DONE:  w = '{OP_DONE,  C_NEVER,    UA_IDLE};
			UA_EMIT:  w = '{OP_EMIT,  C_OUT_BUSY, UA_EMIT};
			UA_BACK:  w = '{OP_NONE,  C_ALWAYS,   UA_IDLE};
			default:  w = '{OP_NONE,  C_ALWAYS,   UA_IDLE};
		endcase
		return w;
	endfunction

	// leap from year mod 4 and year mod 400
	function automatic logic is_leap(logic [1:0] ylo, logic [8:0] r400);
		return (ylo == 2'd0) && (r400 != 9'd100) && (r400 != 9'd200) && (r400 != 9'd300);
	endfunction

	function automatic logic [4:0] month_days(logic [3:0] m, logic leap);
		logic [4:0] n;
		case (m)
			4'd2:    n = leap ? 5'd29 : 5'd28;
			4'd4:    n = 5'd30;
			4'd6:    n = 5'd30;
			4'd9:    n = 5'd30;
			4'd11:   n = 5'd30;
			default: n = 5'd31;
		endcase
		return n;
	endfunction

	function automatic logic [8:0] days_before_month(logic [3:0] m, logic leap);
		logic [8:0] n;
		case (m)
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n + {8'd0, leap && (m > 4'd2)};
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/gregorian_date_add_sub_days.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_date_add_sub_days: shift a Gregorian date by a day count
// Microcoded datapath that walks years, then months, forward or backward.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                     | tuser
//  s_axis   | in  | day, month, year, day_count, pad       | mode (1 = subtract)
//  m_axis   | out | out_day, out_month, out_year, pad      | out_of_range
//
//  an item crosses Y years (up to about 180), then steps M months (up to 11);
//  the year loop runs one year per cycle
//  the result sits in an output register, so the next item is taken while it waits
//  a stalled output holds the program at its emit step only
//  reset clears the step counter and the output valid flag
// ----------------------------------------------------------------------------
module gregorian_date_add_sub_days (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_axis_tvalid,
	output logic                                 s_axis_tready,
	// day[4:0], month[8:5], year[24:9], day_count[40:25], zero[47:41]
	input  wire  [gdas_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// mode[0]
	input  wire                                  s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire                                  m_axis_tready,
	// out_day[4:0], out_month[8:5], out_year[24:9], zero[31:25]
	output logic [gdas_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// out_of_range[0]
	output logic                                 m_axis_tuser
);
	import gdas_pkg::*;

	uword_t ctl;
	flags_t flags;
	logic   idle;

	logic        mode_q;
	logic [4:0]  day_raw_q;
	logic [3:0]  month_raw_q;
	logic [15:0] year_raw_q;
	logic [15:0] cnt_q;
	logic [15:0] year_q;
	logic [7:0]  quo_q;
	logic [8:0]  r400_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [8:0]  doy_q;
	logic [16:0] acc_q;

	logic [4:0]  res_day_q;
	logic [3:0]  res_month_q;
	logic [15:0] res_year_q;
	logic        res_oor_q;

	logic [4:0]  out_day_q;
	logic [3:0]  out_month_q;
	logic [15:0] out_year_q;
	logic        out_oor_q;
	logic        out_valid_q;

	logic        leap;
	logic [8:0]  ylen;
	logic        fits;
	logic        at_limit;
	logic [4:0]  dim;
	logic        more;
	logic        out_busy;
	logic [31:0] prod;
	logic [9:0]  rem_raw;
	logic [8:0]  rem_fix;
	logic [3:0]  month_c;
	logic [4:0]  lim;
	logic [4:0]  day_c;

	gdas_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl),
		.idle   (idle)
	);

	assign s_axis_tready = idle;

	assign leap     = is_leap(year_q[1:0], r400_q);
	assign ylen     = 9'(YEAR_DAYS) + {8'd0, leap};
	assign fits     = acc_q < {8'd0, ylen};
	assign at_limit = mode_q ? (year_q == 16'd0) : (year_q == 16'hFFFF);
	assign dim      = month_days(month_q, leap);
	assign more     = (month_q < 4'(MONTHS)) && (acc_q >= {12'd0, dim});
	assign out_busy = out_valid_q && !m_axis_tready;

	assign flags.no_input = !s_axis_tvalid;
	assign flags.advance  = !fits && !at_limit;
	assign flags.fits     = fits;
	assign flags.more     = more;
	assign flags.out_busy = out_busy;

	// year mod 400 through a reciprocal multiply and one correction
	assign prod    = 32'(year_q) * 32'(QUO_MUL);
	assign rem_raw = 10'(17'(year_q) - 17'(quo_q) * 17'(LEAP_CYCLE));
	assign rem_fix = (rem_raw >= 10'(LEAP_CYCLE)) ? 9'(rem_raw - 10'(LEAP_CYCLE))
	                                              : 9'(rem_raw);

	assign month_c = (month_raw_q == 4'd0) ? 4'd1 :
	                 (month_raw_q > 4'(MONTHS)) ? 4'(MONTHS) : month_raw_q;
	assign lim     = month_days(month_c, leap);
	assign day_c   = (day_raw_q == 5'd0) ? 5'd1 :
	                 (day_raw_q > lim) ? lim : day_raw_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: begin
				mode_q      <= s_axis_tuser;
				day_raw_q   <= s_axis_tdata[4:0];
				month_raw_q <= s_axis_tdata[8:5];
				year_raw_q  <= s_axis_tdata[24:9];
				cnt_q       <= s_axis_tdata[40:25];
				year_q      <= s_axis_tdata[24:9];
			end
			OP_QUO: begin
				quo_q <= 8'(prod >> QUO_SHIFT);
			end
			OP_REM: begin
				r400_q <= rem_fix;
			end
			OP_CLAMP: begin
				month_q <= month_c;
				day_q   <= day_c;
			end
			OP_DOY: begin
				doy_q <= days_before_month(month_q, leap) + 9'(day_q) - 9'd1;
			end
			OP_PREP: begin
				// subtract counts back from the last day of the year
				if (mode_q) begin
					acc_q <= 17'(ylen - 9'd1 - doy_q) + 17'(cnt_q);
				end else begin
					acc_q <= 17'(doy_q) + 17'(cnt_q);
				end
			end
			OP_YSTEP: begin
				if (!fits && !at_limit) begin
					acc_q <= acc_q - 17'(ylen);
					if (mode_q) begin
						year_q <= year_q - 16'd1;
						r400_q <= (r400_q == 9'd0) ? 9'(LEAP_CYCLE - 1) : r400_q - 9'd1;
					end else begin
						year_q <= year_q + 16'd1;
						r400_q <= (r400_q == 9'(LEAP_CYCLE - 1)) ? 9'd0 : r400_q + 9'd1;
					end
				end
			end
			OP_YEND: begin
				if (mode_q) begin
					acc_q <= 17'(ylen - 9'd1) - acc_q;
				end
				month_q <= 4'd1;
			end
			OP_MSTEP: begin
				if (more) begin
					acc_q   <= acc_q - 17'(dim);
					month_q <= month_q + 4'd1;
				end
			end
			OP_DONE: begin
				res_day_q   <= 5'(acc_q + 17'd1);
				res_month_q <= month_q;
				res_year_q  <= year_q;
				res_oor_q   <= 1'b0;
			end
			OP_FAIL: begin
				res_day_q   <= day_raw_q;
				res_month_q <= month_raw_q;
				res_year_q  <= year_raw_q;
				res_oor_q   <= 1'b1;
			end
			OP_EMIT: begin
				if (!out_busy) begin
					out_day_q   <= res_day_q;
					out_month_q <= res_month_q;
					out_year_q  <= res_year_q;
					out_oor_q   <= res_oor_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.op == OP_EMIT && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_year_q, out_month_q, out_day_q};
	assign m_axis_tuser  = out_oor_q;

	// one transaction in flight: no second accept until the program returns
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while an item is in progress");

	a_r400_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == OP_YSTEP |-> r400_q < 9'(LEAP_CYCLE))
		else $error("year mod 400 tracker out of range");

	a_month_walk: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == OP_MSTEP |-> acc_q < 17'(ylen))
		else $error("month walk started beyond the year length");

	a_result_date: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_oor_q |->
			out_month_q >= 4'd1 && out_month_q <= 4'(MONTHS) && out_day_q != 5'd0)
		else $error("in-range result with an invalid date");

endmodule
`default_nettype wire

/* hw/rtl/gdas_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gdas_seq: microcode sequencer
// Step counter over the control program, with conditional jumps taken on
// datapath flags.
// ----------------------------------------------------------------------------
module gdas_seq (
	input  wire              clk,
	input  wire              arst_n,
	input  gdas_pkg::flags_t flags,
	output gdas_pkg::uword_t ctl,
	output logic             idle
);
	import gdas_pkg::*;

	upc_t   pc_q;
	uword_t word;
	logic   take;

	assign word = urom(pc_q);
	assign ctl  = word;
	assign idle = (pc_q == UA_IDLE);

	always_comb begin
		case (word.cond)
			C_NEVER:    take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_INPUT: take = flags.no_input;
			C_ADVANCE:  take = flags.advance;
			C_FITS:     take = flags.fits;
			C_MORE:     take = flags.more;
			C_OUT_BUSY: take = flags.out_busy;
			default:    take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= UA_IDLE;
		end else if (take) begin
			pc_q <= word.target;
		end else begin
			pc_q <= pc_q + upc_t'(1);
		end
	end

endmodule
`default_nettype wire
